[rtl/core/assert_macros.svh]
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SPQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;

  typedef enum logic {
    CmdEnq = 1'b0,
    CmdDeq = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic signed [DataW-1:0] data;
  } cell_ctrl_t;

endpackage

[rtl/core/spq_cell.sv]
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    occ_i,
  input  logic                    prev_keep_i,
  input  logic signed [DataW-1:0] prev_data_i,
  input  logic signed [DataW-1:0] next_data_i,
  output logic                    keep_o,
  output logic signed [DataW-1:0] data_o
);

  logic signed [DataW-1:0] data_q;
  logic signed [DataW-1:0] data_d;

  // Hold when the stored word is at least the new one, so equal words stay first.
  assign keep_o = occ_i && (data_q >= ctrl_i.data);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.remove) begin
      data_d = next_data_i;
    end else if (ctrl_i.insert && !keep_o) begin
      // Take the new word at the insert point, otherwise shift down.
      data_d = prev_keep_i ? ctrl_i.data : prev_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[rtl/core/sorted_array_priority_queue_core.sv]
// Channel  | Handshake                | Word
// ---------+--------------------------+-------------------------------------
// in       | in_valid_i / in_stall_o  | command_i, value_i
// out      | out_valid_o / out_stall_i| status_o, removed_value_o, count_o
//
// One command per cycle while in_stall_o is low: every cell of the chain
// compares against the new word and shifts in the same cycle, so an accepted
// command updates the queue at once; its result is registered on acceptance.
// in_stall_o is high only while a result waits and out_stall_i holds it.
// Reset empties the queue (count to zero) and clears the output valid.
`include "assert_macros.svh"

module sorted_array_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic        [StatusW-1:0] status_o,
  output logic signed [DataW-1:0]   removed_value_o,
  output logic        [CountW-1:0]  count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                    in_acc;
  logic                    deq_ok;
  cmd_e                    cmd;
  logic                    full;
  logic                    empty;
  cell_ctrl_t              ctrl;
  status_e                 status;

  logic [CntW-1:0]         cnt_q;
  logic [CntW-1:0]         cnt_d;

  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        keep;
  logic signed [DataW-1:0] ent [DEPTH];

  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [StatusW-1:0]      status_q;
  logic signed [DataW-1:0] removed_q;
  logic signed [DataW-1:0] removed_d;
  logic [CountW-1:0]       count_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(command_i);
  assign full       = (cnt_q == CntW'(DEPTH));
  assign empty      = (cnt_q == '0);
  assign deq_ok     = in_acc && (cmd == CmdDeq) && !empty;

  always_comb begin
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    ctrl.data   = value_i;
    status      = StOk;
    removed_d   = '0;
    cnt_d       = cnt_q;
    case (cmd)
      CmdEnq: begin
        if (full) begin
          status = StFull;
        end else begin
          ctrl.insert = in_acc;
          if (in_acc) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      CmdDeq: begin
        if (empty) begin
          status = StEmpty;
        end else begin
          ctrl.remove = in_acc;
          removed_d   = ent[0];
          if (in_acc) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      default: begin
        status = StOk;
      end
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                    prev_keep;
    logic signed [DataW-1:0] prev_data;
    logic signed [DataW-1:0] next_data;

    assign occ[k] = (cnt_q > CntW'(k));

    if (k == 0) begin : g_head
      // Head cell always sits at the insert point when it does not hold.
      assign prev_keep = 1'b1;
      assign prev_data = value_i;
    end else begin : g_body
      assign prev_keep = keep[k-1];
      assign prev_data = ent[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign next_data = ent[k];
    end else begin : g_mid
      assign next_data = ent[k+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[k]),
      .prev_keep_i (prev_keep),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .keep_o      (keep[k]),
      .data_o      (ent[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = in_acc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q  <= status;
      removed_q <= removed_d;
      count_q   <= CountW'(cnt_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = count_q;

  `SPQ_NEVER(a_cnt_range, cnt_q > CntW'(DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_cnt_hold, !in_acc |=> $stable(cnt_q), "count moved without a command")
  `SPQ_ASSERT(a_deq_head, deq_ok |=> (removed_value_o == $past(ent[0])), "dequeue lost head word")

endmodule

[sim/sorted_array_priority_queue_core_tb.sv]
module sorted_array_priority_queue_core_tb
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 1250;
  localparam int unsigned IdlePct    = 32;

  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] removed;
    logic [CountW-1:0]       count;
  } pq_result_t;

  // Golden copy of the queue plus the results it promises, in order.
  class pq_scoreboard;
    logic signed [DataW-1:0] cells[DEPTH];
    int unsigned             held;
    pq_result_t              expected_q[$];
    int unsigned             errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void note_command(cmd_e cmd, logic signed [DataW-1:0] val);
      pq_result_t  res;
      int unsigned pos;
      res.status  = StOk;
      res.removed = '0;
      if (cmd == CmdEnq) begin
        if (held >= DEPTH) begin
          res.status = StFull;
        end else begin
          // shift smaller entries down; equal ones stay ahead of the new word
          pos = held;
          while (pos > 0 && cells[pos-1] < val) begin
            cells[pos] = cells[pos-1];
            pos--;
          end
          cells[pos] = val;
          held++;
        end
      end else begin
        if (held == 0) begin
          res.status = StEmpty;
        end else begin
          res.removed = cells[0];
          for (int unsigned k = 0; k + 1 < held; k++) cells[k] = cells[k+1];
          held--;
        end
      end
      res.count = held[CountW-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic signed [DataW-1:0] removed,
                               logic [CountW-1:0] count);
      pq_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with none expected: status %0d removed %0d count %0d",
                 $time, status, removed, count);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, exp_res.status, status);
        errors++;
      end
      if (removed !== exp_res.removed) begin
        $display("%0t: removed_value mismatch: expected %0d actual %0d",
                 $time, exp_res.removed, removed);
        errors++;
      end
      if (count !== exp_res.count) begin
        $display("%0t: count mismatch: expected %0d actual %0d",
                 $time, exp_res.count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      command     = 1'b0;
  logic signed [DataW-1:0]   value       = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic        [StatusW-1:0] status;
  logic signed [DataW-1:0]   removed_value;
  logic        [CountW-1:0]  count;

  pq_scoreboard sb = new();
  bit           quiet        = 1'b0;
  int unsigned  hold_request = 0;
  int unsigned  hold_left    = 0;
  int unsigned  cycles       = 0;

  sorted_array_priority_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .removed_value_o(removed_value),
    .count_o        (count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(status, removed_value, count);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IdlePct);
      end
    end
  end

  task automatic send_word(input cmd_e cmd, input logic signed [DataW-1:0] val);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (in_stall);
    sb.note_command(cmd, val);
  endtask

  // Stop offering and hold until every promised result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed($urandom_range(15)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  initial begin
    int unsigned enq_pct;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty refusal, extremes, duplicates, full refusal, full drain
    send_word(CmdDeq, 32'sh1234_5678);
    send_word(CmdEnq, 32'sd0);
    send_word(CmdEnq, 32'sh7fff_ffff);
    send_word(CmdEnq, 32'sh8000_0000);
    send_word(CmdEnq, -32'sd1);
    send_word(CmdEnq, 32'sd1);
    send_word(CmdEnq, 32'sh7fff_ffff);
    send_word(CmdEnq, 32'sh8000_0000);
    send_word(CmdEnq, 32'sd5);
    send_word(CmdEnq, 32'sd100);
    send_word(CmdEnq, 32'sh8000_0000);
    repeat (8) send_word(CmdDeq, -32'sd1);
    send_word(CmdDeq, 32'sh7fff_ffff);
    send_word(CmdEnq, 32'sd42);
    send_word(CmdDeq, 32'sd0);

    enq_pct = 50;
    for (int unsigned i = 0; i < NumRandom; i++) begin
      // swing between filling, draining and balanced traffic
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 80;
          1:       enq_pct = 20;
          default: enq_pct = 50;
        endcase
      end
      if (i == 300) quiet = 1'b1;
      if (i == 450) quiet = 1'b0;
      if (i == 600) hold_request = 150;
      if (i == 800) drain_results();
      if ($urandom_range(99) < enq_pct) send_word(CmdEnq, pick_value());
      else send_word(CmdDeq, $signed($urandom));
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
